@@ hdl/per_cell_mlp_backprop_trainer_defines.svh @@
// Assertion macros shared by the trainer RTL.
`ifndef PER_CELL_MLP_BACKPROP_TRAINER_DEFINES_SVH
`define PER_CELL_MLP_BACKPROP_TRAINER_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define PMBT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pmbt assertion failed");

// Consequent checked in the cycle after the antecedent.
`define PMBT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pmbt assertion failed");

`endif

@@ hdl/pmbt_pkg.sv @@
// Shared constants, types and fixed-point helpers of the per-cell trainer.
package pmbt_pkg;

	localparam int GRID_X              = 64;
	localparam int GRID_Y              = 64;
	localparam int HIDDEN_UNITS        = 8;
	localparam int SIGMOID_TABLE_DEPTH = 1024;

	localparam int NCELLS = GRID_X * GRID_Y;
	localparam int ROWS   = NCELLS * HIDDEN_UNITS;
	localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int HU_W   = (HIDDEN_UNITS > 1) ? $clog2(HIDDEN_UNITS) : 1;
	localparam int SIG_W  = $clog2(SIGMOID_TABLE_DEPTH);
	localparam int ACC_W  = 52;

	localparam logic       OP_TRAIN       = 1'b0;
	localparam logic       OP_WRITE       = 1'b1;
	localparam logic [1:0] SLOT_IN_A      = 2'd0;
	localparam logic [1:0] SLOT_IN_B      = 2'd1;
	localparam logic [1:0] SLOT_OUT       = 2'd2;
	localparam logic [1:0] CFG_LEARN_RATE = 2'd0;
	localparam logic [1:0] CFG_MOMENTUM   = 2'd1;

	// one memory row per (cell, hidden unit)
	typedef struct packed {
		logic signed [31:0] wo;
		logic signed [31:0] w1;
		logic signed [31:0] w0;
	} row_t;

	typedef enum logic [4:0] {
		ST_CLEAR, ST_IDLE, ST_WR_RD, ST_WR_WB,
		ST_F_RD, ST_F_M0, ST_F_M1, ST_F_M2, ST_F_M3, ST_F_M4,
		ST_O_SIG, ST_O_LD, ST_E_M0, ST_E_M1, ST_E_M2, ST_E_M3,
		ST_B_RD, ST_B_M0, ST_B_M1, ST_B_M2, ST_B_M3, ST_B_M4, ST_B_M5, ST_B_M6,
		ST_B_M7, ST_B_M8, ST_B_M9, ST_B_M10, ST_B_M11, ST_B_M12,
		ST_DONE
	} state_t;

	typedef logic [16:0] sig_tab_t [SIGMOID_TABLE_DEPTH];

	function automatic logic signed [31:0] sat32(logic signed [ACC_W-1:0] v);
		if (v > 52'sd2147483647)
			return 32'sh7fffffff;
		else if (v < -52'sd2147483648)
			return 32'sh80000000;
		else
			return v[31:0];
	endfunction

	// remainder of a 6-bit value by a constant, restoring subtraction
	function automatic logic [5:0] umod6(logic [5:0] v, int m);
		logic [15:0] r;
		r = {10'd0, v};
		for (int b = 5; b >= 0; b--) begin
			if (r >= 16'(m << b))
				r = r - 16'(m << b);
		end
		return r[5:0];
	endfunction

	// elaboration-time only: shift-subtract quotient
	function automatic logic [63:0] udiv64(logic [63:0] n, logic [63:0] d);
		logic [63:0] q;
		logic [63:0] r;
		q = '0;
		r = '0;
		for (int i = 63; i >= 0; i--) begin
			r = {r[62:0], n[i]};
			if (r >= d) begin
				r    = r - d;
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	// exp(-u) in Q1.31 for Q16.16 u: Taylor on u/256, then eight squarings
	function automatic logic [63:0] exp_neg(logic [63:0] u);
		logic [63:0] r;
		logic [63:0] r2;
		logic [63:0] r3;
		logic [63:0] r4;
		logic [63:0] e;
		r  = u << 7;
		r2 = (r * r) >> 31;
		r3 = (r2 * r) >> 31;
		r4 = (r3 * r) >> 31;
		e  = 64'h8000_0000 + (r2 >> 1) + r4 / 64'd24 - r - r3 / 64'd6;
		for (int n = 0; n < 8; n++)
			e = (e * e + 64'h4000_0000) >> 31;
		return e;
	endfunction

	function automatic sig_tab_t sig_build();
		sig_tab_t           t;
		logic signed [63:0] x;
		logic [63:0]        u;
		logic [63:0]        e;
		logic [63:0]        d;
		logic [63:0]        num;
		for (int i = 0; i < SIGMOID_TABLE_DEPTH; i++) begin
			x   = 64'((longint'(i) <<< 20) / SIGMOID_TABLE_DEPTH) - 64'sd524288;
			u   = (x >= 0) ? x : -x;
			e   = exp_neg(u);
			d   = 64'h8000_0000 + e;
			num = (x >= 0) ? (64'd1 << 47) : (e << 16);
			t[i] = 17'(udiv64(num + (d >> 1), d));
		end
		return t;
	endfunction

	localparam sig_tab_t SIG_TAB = sig_build();

	// saturating table sigmoid over [-8, 8)
	function automatic logic [16:0] sigmoid(logic signed [31:0] x);
		logic [SIG_W-1:0] idx;
		logic [63:0]      off;
		off = {44'd0, 20'(x + 32'sd524288)};
		if (x < -32'sd524288)
			idx = '0;
		else if (x >= 32'sd524288)
			idx = SIG_W'(SIGMOID_TABLE_DEPTH - 1);
		else
			idx = SIG_W'((off * 64'(SIGMOID_TABLE_DEPTH)) >> 20);
		return SIG_TAB[idx];
	endfunction

endpackage

@@ hdl/per_cell_mlp_backprop_trainer.sv @@
// Per-cell trainer: each of the GRID_X*GRID_Y cells owns a 2-input, HIDDEN_UNITS-hidden,
// 1-output sigmoid network in Q16.16. Weights and momentum terms live in two row memories
// (one row per cell and hidden unit). Every product of the forward, backward and update
// passes of a train item goes through the one shared multiplier, and the sigmoid table
// has a registered read; a weight write reads the row, merges the new weight and writes
// it back (only for a valid slot), then gives a result. After reset the momentum memory
// is zeroed one row a cycle, all GRID_X*GRID_Y*HIDDEN_UNITS rows (32768), with in_stall
// high; configuration writes are taken at any time. One item is in work at a time; the
// output register lets the next item start while a result waits to be taken.
`include "per_cell_mlp_backprop_trainer_defines.svh"

module per_cell_mlp_backprop_trainer (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               opcode,
	input  logic [5:0]         cell_x,
	input  logic [5:0]         cell_y,
	input  logic signed [31:0] feature_a,
	input  logic signed [31:0] feature_b,
	input  logic [16:0]        target,
	input  logic [2:0]         hidden_unit,
	input  logic [1:0]         weight_slot,
	input  logic signed [31:0] weight_value,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [16:0]        net_output,
	output logic [15:0]        half_sq_error,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [16:0]        cfg_data
);

	localparam int RW  = pmbt_pkg::ROW_W;
	localparam int AW  = pmbt_pkg::ACC_W;
	localparam int HUW = pmbt_pkg::HU_W;

	pmbt_pkg::state_t state_q, state_d;

	logic [RW-1:0]  clr_q;
	logic [HUW-1:0] h_q;
	logic           h_last;

	logic [16:0] eta_q, alf_q;

	logic               op_q;
	logic [RW-1:0]      base_q;
	logic signed [31:0] fa_q, fb_q;
	logic [16:0]        tgt_q;
	logic [2:0]         wunit_q;
	logic [1:0]         wslot_q;
	logic signed [31:0] wval_q;

	pmbt_pkg::row_t     wrow_q, mrow_q, nw_q, nm_q;
	logic signed [31:0] bias_ih_q;
	logic signed [AW-1:0] acc_q, oacc_q;
	logic [16:0]        hid_q [pmbt_pkg::HIDDEN_UNITS];
	logic [16:0]        o_q;
	logic [16:0]        sig_q;
	logic [15:0]        hs_q;
	logic signed [31:0] dout_q, dhid_q, t1_q;

	logic               out_valid_q;
	logic [16:0]        net_output_q;
	logic [15:0]        half_sq_error_q;

	// memory ports
	logic               w_we, m_we;
	logic [RW-1:0]      w_waddr, m_waddr, raddr;
	pmbt_pkg::row_t     w_wdata, m_wdata, w_rdata, m_rdata;

	// multiplier
	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] prod;

	logic signed [AW-1:0] fl;
	logic signed [31:0]   chain;
	logic signed [17:0]   err;
	logic [16:0]          one_m_o, one_m_hid, hid_cur, sig_out;
	logic signed [31:0]   sig_in;
	logic signed [31:0]   dw;
	logic [RW-1:0]        row_cur, row_wr;
	logic                 wr_ok;
	logic                 in_acc, out_acc;
	logic [5:0]           cx, cy;
	logic [RW-1:0]        base_in;

	assign in_acc  = in_valid && !in_stall;
	assign out_acc = out_valid_q && !out_stall;
	assign h_last  = (h_q == HUW'(pmbt_pkg::HIDDEN_UNITS - 1));

	assign cx      = pmbt_pkg::umod6(cell_x, pmbt_pkg::GRID_X);
	assign cy      = pmbt_pkg::umod6(cell_y, pmbt_pkg::GRID_Y);
	assign base_in = RW'((int'(cy) * pmbt_pkg::GRID_X + int'(cx)) * pmbt_pkg::HIDDEN_UNITS);

	assign row_cur = base_q + RW'(h_q);
	assign row_wr  = base_q + RW'(wunit_q);
	assign wr_ok   = (int'(wunit_q) < pmbt_pkg::HIDDEN_UNITS)
		&& (wslot_q inside {pmbt_pkg::SLOT_IN_A, pmbt_pkg::SLOT_IN_B, pmbt_pkg::SLOT_OUT});

	// floor(product / 2^16), and its saturated form
	assign fl        = {{2{prod[65]}}, prod[65:16]};
	assign chain     = pmbt_pkg::sat32(fl);
	assign err       = $signed({1'b0, tgt_q}) - $signed({1'b0, o_q});
	assign one_m_o   = 17'd65536 - o_q;
	assign hid_cur   = hid_q[h_q];
	assign one_m_hid = 17'd65536 - hid_cur;
	assign sig_out   = pmbt_pkg::sigmoid(sig_in);

	// accumulated dw is the second term added to the first held in t1_q
	assign dw = pmbt_pkg::sat32({{(AW-32){t1_q[31]}}, t1_q} + {{(AW-32){chain[31]}}, chain});

	assign in_stall      = (state_q != pmbt_pkg::ST_IDLE);
	assign cfg_ready     = 1'b1;
	assign out_valid     = out_valid_q;
	assign net_output    = net_output_q;
	assign half_sq_error = half_sq_error_q;

	pmbt_ram #(.WIDTH($bits(pmbt_pkg::row_t)), .DEPTH(pmbt_pkg::ROWS)) u_wram (
		.clk   (clk),
		.we    (w_we),
		.waddr (w_waddr),
		.wdata (w_wdata),
		.raddr (raddr),
		.rdata (w_rdata)
	);

	pmbt_ram #(.WIDTH($bits(pmbt_pkg::row_t)), .DEPTH(pmbt_pkg::ROWS)) u_mram (
		.clk   (clk),
		.we    (m_we),
		.waddr (m_waddr),
		.wdata (m_wdata),
		.raddr (raddr),
		.rdata (m_rdata)
	);

	pmbt_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (prod)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			pmbt_pkg::ST_CLEAR: begin
				if (clr_q == RW'(pmbt_pkg::ROWS - 1))
					state_d = pmbt_pkg::ST_IDLE;
			end
			pmbt_pkg::ST_IDLE: begin
				if (in_acc)
					state_d = (opcode == pmbt_pkg::OP_WRITE) ? pmbt_pkg::ST_WR_RD
						: pmbt_pkg::ST_F_RD;
			end
			pmbt_pkg::ST_WR_RD: state_d = pmbt_pkg::ST_WR_WB;
			pmbt_pkg::ST_WR_WB: state_d = pmbt_pkg::ST_DONE;
			pmbt_pkg::ST_F_RD:  state_d = pmbt_pkg::ST_F_M0;
			pmbt_pkg::ST_F_M0:  state_d = pmbt_pkg::ST_F_M1;
			pmbt_pkg::ST_F_M1:  state_d = pmbt_pkg::ST_F_M2;
			pmbt_pkg::ST_F_M2:  state_d = pmbt_pkg::ST_F_M3;
			pmbt_pkg::ST_F_M3:  state_d = pmbt_pkg::ST_F_M4;
			pmbt_pkg::ST_F_M4:  state_d = h_last ? pmbt_pkg::ST_O_SIG : pmbt_pkg::ST_F_RD;
			pmbt_pkg::ST_O_SIG: state_d = pmbt_pkg::ST_O_LD;
			pmbt_pkg::ST_O_LD:  state_d = pmbt_pkg::ST_E_M0;
			pmbt_pkg::ST_E_M0:  state_d = pmbt_pkg::ST_E_M1;
			pmbt_pkg::ST_E_M1:  state_d = pmbt_pkg::ST_E_M2;
			pmbt_pkg::ST_E_M2:  state_d = pmbt_pkg::ST_E_M3;
			pmbt_pkg::ST_E_M3:  state_d = pmbt_pkg::ST_B_RD;
			pmbt_pkg::ST_B_RD:  state_d = pmbt_pkg::ST_B_M0;
			pmbt_pkg::ST_B_M0:  state_d = pmbt_pkg::ST_B_M1;
			pmbt_pkg::ST_B_M1:  state_d = pmbt_pkg::ST_B_M2;
			pmbt_pkg::ST_B_M2:  state_d = pmbt_pkg::ST_B_M3;
			pmbt_pkg::ST_B_M3:  state_d = pmbt_pkg::ST_B_M4;
			pmbt_pkg::ST_B_M4:  state_d = pmbt_pkg::ST_B_M5;
			pmbt_pkg::ST_B_M5:  state_d = pmbt_pkg::ST_B_M6;
			pmbt_pkg::ST_B_M6:  state_d = pmbt_pkg::ST_B_M7;
			pmbt_pkg::ST_B_M7:  state_d = pmbt_pkg::ST_B_M8;
			pmbt_pkg::ST_B_M8:  state_d = pmbt_pkg::ST_B_M9;
			pmbt_pkg::ST_B_M9:  state_d = pmbt_pkg::ST_B_M10;
			pmbt_pkg::ST_B_M10: state_d = pmbt_pkg::ST_B_M11;
			pmbt_pkg::ST_B_M11: state_d = pmbt_pkg::ST_B_M12;
			pmbt_pkg::ST_B_M12: state_d = h_last ? pmbt_pkg::ST_DONE : pmbt_pkg::ST_B_RD;
			pmbt_pkg::ST_DONE: begin
				if (!out_valid_q || !out_stall)
					state_d = pmbt_pkg::ST_IDLE;
			end
			default: state_d = pmbt_pkg::ST_IDLE;
		endcase
	end

	// memory and multiplier controls
	always_comb begin
		w_we    = 1'b0;
		m_we    = 1'b0;
		w_waddr = row_cur;
		m_waddr = row_cur;
		raddr   = row_cur;
		w_wdata = w_rdata;
		m_wdata = '0;
		mul_a   = '0;
		mul_b   = '0;
		sig_in  = pmbt_pkg::sat32(oacc_q);
		case (state_q)
			pmbt_pkg::ST_CLEAR: begin
				m_we    = 1'b1;
				m_waddr = clr_q;
			end
			pmbt_pkg::ST_WR_RD: raddr = row_wr;
			pmbt_pkg::ST_WR_WB: begin
				w_we    = wr_ok;
				w_waddr = row_wr;
				case (wslot_q)
					pmbt_pkg::SLOT_IN_A: w_wdata.w0 = wval_q;
					pmbt_pkg::SLOT_IN_B: w_wdata.w1 = wval_q;
					pmbt_pkg::SLOT_OUT:  w_wdata.wo = wval_q;
					default:             w_wdata = w_rdata;
				endcase
			end
			pmbt_pkg::ST_F_M0: begin
				mul_a = {fa_q[31], fa_q};
				mul_b = {w_rdata.w0[31], w_rdata.w0};
			end
			pmbt_pkg::ST_F_M1: begin
				mul_a = {fb_q[31], fb_q};
				mul_b = {wrow_q.w1[31], wrow_q.w1};
			end
			pmbt_pkg::ST_F_M2: begin
				sig_in = pmbt_pkg::sat32(acc_q + fl);
			end
			pmbt_pkg::ST_F_M3: begin
				// table read of the hidden sigmoid lands this cycle
				mul_a = {16'd0, sig_q};
				mul_b = {wrow_q.wo[31], wrow_q.wo};
			end
			pmbt_pkg::ST_E_M0: begin
				mul_a = {{15{err[17]}}, err};
				mul_b = {{15{err[17]}}, err};
			end
			pmbt_pkg::ST_E_M1: begin
				mul_a = {{15{err[17]}}, err};
				mul_b = {16'd0, o_q};
			end
			pmbt_pkg::ST_E_M2: begin
				mul_a = {chain[31], chain};
				mul_b = {16'd0, one_m_o};
			end
			pmbt_pkg::ST_B_M0: begin
				mul_a = {w_rdata.wo[31], w_rdata.wo};
				mul_b = {dout_q[31], dout_q};
			end
			pmbt_pkg::ST_B_M1: begin
				mul_a = {chain[31], chain};
				mul_b = {16'd0, hid_cur};
			end
			pmbt_pkg::ST_B_M2: begin
				mul_a = {chain[31], chain};
				mul_b = {16'd0, one_m_hid};
			end
			pmbt_pkg::ST_B_M3: begin
				mul_a = {16'd0, eta_q};
				mul_b = {fa_q[31], fa_q};
			end
			pmbt_pkg::ST_B_M4, pmbt_pkg::ST_B_M7: begin
				mul_a = {chain[31], chain};
				mul_b = {dhid_q[31], dhid_q};
			end
			pmbt_pkg::ST_B_M5: begin
				mul_a = {16'd0, alf_q};
				mul_b = {mrow_q.w0[31], mrow_q.w0};
			end
			pmbt_pkg::ST_B_M6: begin
				mul_a = {16'd0, eta_q};
				mul_b = {fb_q[31], fb_q};
			end
			pmbt_pkg::ST_B_M8: begin
				mul_a = {16'd0, alf_q};
				mul_b = {mrow_q.w1[31], mrow_q.w1};
			end
			pmbt_pkg::ST_B_M9: begin
				mul_a = {16'd0, eta_q};
				mul_b = {16'd0, hid_cur};
			end
			pmbt_pkg::ST_B_M10: begin
				mul_a = {chain[31], chain};
				mul_b = {dout_q[31], dout_q};
			end
			pmbt_pkg::ST_B_M11: begin
				mul_a = {16'd0, alf_q};
				mul_b = {mrow_q.wo[31], mrow_q.wo};
			end
			pmbt_pkg::ST_B_M12: begin
				w_we       = 1'b1;
				m_we       = 1'b1;
				w_wdata.w0 = nw_q.w0;
				w_wdata.w1 = nw_q.w1;
				m_wdata.w0 = nm_q.w0;
				m_wdata.w1 = nm_q.w1;
				m_wdata.wo = dw;
				w_wdata.wo = pmbt_pkg::sat32({{(AW-32){wrow_q.wo[31]}}, wrow_q.wo}
					+ {{(AW-32){dw[31]}}, dw});
			end
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pmbt_pkg::ST_CLEAR;
			clr_q       <= '0;
			h_q         <= '0;
			eta_q       <= 17'd32768;
			alf_q       <= 17'd58982;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == pmbt_pkg::ST_CLEAR)
				clr_q <= clr_q + RW'(1);
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == pmbt_pkg::CFG_LEARN_RATE)
					eta_q <= cfg_data;
				else if (cfg_index == pmbt_pkg::CFG_MOMENTUM)
					alf_q <= cfg_data;
			end
			if (state_q == pmbt_pkg::ST_IDLE || state_q == pmbt_pkg::ST_O_SIG)
				h_q <= '0;
			else if (state_q == pmbt_pkg::ST_F_M4 || state_q == pmbt_pkg::ST_B_M12)
				h_q <= h_last ? '0 : h_q + HUW'(1);
			if (state_q == pmbt_pkg::ST_DONE && (!out_valid_q || !out_stall))
				out_valid_q <= 1'b1;
			else if (out_acc)
				out_valid_q <= 1'b0;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		// sigmoid table with registered read
		sig_q <= sig_out;
		if (in_acc) begin
			op_q    <= opcode;
			base_q  <= base_in;
			fa_q    <= feature_a;
			fb_q    <= feature_b;
			tgt_q   <= target;
			wunit_q <= hidden_unit;
			wslot_q <= weight_slot;
			wval_q  <= weight_value;
		end
		case (state_q)
			pmbt_pkg::ST_F_M0: begin
				wrow_q <= w_rdata;
				if (h_q == '0) begin
					// unit 0 row supplies both biases
					bias_ih_q <= w_rdata.w0;
					oacc_q    <= {{(AW-32){w_rdata.wo[31]}}, w_rdata.wo};
				end
			end
			pmbt_pkg::ST_F_M1: acc_q <= {{(AW-32){bias_ih_q[31]}}, bias_ih_q} + fl;
			pmbt_pkg::ST_F_M3: hid_q[h_q] <= sig_q;
			pmbt_pkg::ST_F_M4: oacc_q <= oacc_q + fl;
			pmbt_pkg::ST_O_LD: o_q <= sig_q;
			pmbt_pkg::ST_E_M1: begin
				// err squared is never negative
				if (prod[65:17] > 49'd65535)
					hs_q <= 16'hffff;
				else
					hs_q <= prod[32:17];
			end
			pmbt_pkg::ST_E_M3: dout_q <= chain;
			pmbt_pkg::ST_B_M0: begin
				wrow_q <= w_rdata;
				mrow_q <= m_rdata;
			end
			pmbt_pkg::ST_B_M3: dhid_q <= chain;
			pmbt_pkg::ST_B_M5, pmbt_pkg::ST_B_M8, pmbt_pkg::ST_B_M11: t1_q <= chain;
			pmbt_pkg::ST_B_M6: begin
				nm_q.w0 <= dw;
				nw_q.w0 <= pmbt_pkg::sat32({{(AW-32){wrow_q.w0[31]}}, wrow_q.w0}
					+ {{(AW-32){dw[31]}}, dw});
			end
			pmbt_pkg::ST_B_M9: begin
				nm_q.w1 <= dw;
				nw_q.w1 <= pmbt_pkg::sat32({{(AW-32){wrow_q.w1[31]}}, wrow_q.w1}
					+ {{(AW-32){dw[31]}}, dw});
			end
			pmbt_pkg::ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					net_output_q    <= (op_q == pmbt_pkg::OP_TRAIN) ? o_q : '0;
					half_sq_error_q <= (op_q == pmbt_pkg::OP_TRAIN) ? hs_q : '0;
				end
			end
			default: ;
		endcase
	end

	`PMBT_ASSERT_NEXT(a_accept_leaves_idle, clk, arst_n, in_valid && !in_stall, state_q != pmbt_pkg::ST_IDLE)
	`PMBT_ASSERT_SAME(a_result_from_done, clk, arst_n, $rose(out_valid_q), $past(state_q) == pmbt_pkg::ST_DONE)
	`PMBT_ASSERT_SAME(a_clear_blocks_items, clk, arst_n, state_q == pmbt_pkg::ST_CLEAR, in_stall && !out_valid_q)

endmodule

@@ hdl/pmbt_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
module pmbt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

@@ hdl/pmbt_mul.sv @@
// Shared signed 33x33 multiplier with registered product.
module pmbt_mul (
	input  logic               clk,
	input  logic signed [32:0] a,
	input  logic signed [32:0] b,
	output logic signed [65:0] p
);

	always_ff @(posedge clk) begin
		p <= a * b;
	end

endmodule
